>>> design/esru_pkg.sv
package esru_pkg;

    localparam int IRQ_W         = 5;
    localparam int IRQ_LEVELS_DF = 5;
    localparam int LVL_W         = 3;
    localparam int PSW_W         = 20;
    localparam int CFG_IDX_W     = 2;

    // opcodes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_COND  = 3'd2;
    localparam logic [2:0] OP_IRQ   = 3'd3;
    localparam logic [2:0] OP_EXC   = 3'd4;

    // system register numbers
    localparam logic [4:0] SR_EIPC  = 5'd0;
    localparam logic [4:0] SR_EIPSW = 5'd1;
    localparam logic [4:0] SR_FEPC  = 5'd2;
    localparam logic [4:0] SR_FEPSW = 5'd3;
    localparam logic [4:0] SR_ECR   = 5'd4;
    localparam logic [4:0] SR_PSW   = 5'd5;
    localparam logic [4:0] SR_PIR   = 5'd6;
    localparam logic [4:0] SR_TKCW  = 5'd7;
    localparam logic [4:0] SR_CHCW  = 5'd24;
    localparam logic [4:0] SR_ADTRE = 5'd25;
    localparam logic [4:0] SR_SR29  = 5'd29;
    localparam logic [4:0] SR_SR30  = 5'd30;
    localparam logic [4:0] SR_SR31  = 5'd31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TKCW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SR30 = 2'd2;

    // PSW
    localparam logic [PSW_W-1:0] PSW_MASK = 20'hFF3FF;
    localparam int PSW_ID_B = 12;
    localparam int PSW_AE_B = 13;
    localparam int PSW_EP_B = 14;
    localparam int PSW_NP_B = 15;

    // exception codes and vectors
    localparam logic [7:0]  CODE_IRQ_HI   = 8'hFE;
    localparam logic [15:0] CODE_SPECIAL  = 16'hFF70;
    localparam logic [15:0] VEC_SPECIAL   = 16'hFF60;
    localparam logic [15:0] VEC_LO_MASK   = 16'hFFF0;
    localparam logic [31:0] VEC_DUPLEXED  = 32'hFFFFFFD0;
    localparam logic [15:0] VEC_HI        = 16'hFFFF;
    localparam logic [15:0] FATAL_HI      = 16'hFFFF;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [4:0]       target_id;
        logic [31:0]      write_value;
        logic [15:0]      exception_code;
        logic [31:0]      current_pc;
        logic [IRQ_W-1:0] irq_lines;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_value;
        logic        condition_true;
        logic        pc_redirect;
        logic [31:0] new_pc;
        logic        fatal_valid;
        logic [31:0] fatal_word;
        logic        halted;
    } t_out_item;

    typedef struct packed {
        logic [31:0] processor_id_value;
        logic [31:0] task_control_value;
        logic [31:0] sr30_value;
    } t_cfg;

endpackage

>>> design/esru_core.sv
module esru_core #(
    parameter int IRQ_LEVELS = esru_pkg::IRQ_LEVELS_DF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  esru_pkg::t_in_item   i_item,
    input  esru_pkg::t_cfg       i_cfg,
    output esru_pkg::t_out_item  o_result
);

    localparam int NUM_CHK = (IRQ_LEVELS < esru_pkg::IRQ_W) ? IRQ_LEVELS : esru_pkg::IRQ_W;

    logic [31:0]               r_eipc, n_eipc;
    logic [31:0]               r_eipsw, n_eipsw;
    logic [31:0]               r_fepc, n_fepc;
    logic [31:0]               r_fepsw, n_fepsw;
    logic [31:0]               r_ecr, n_ecr;
    logic [esru_pkg::PSW_W-1:0] r_psw, n_psw;
    logic                      r_cache_en, n_cache_en;
    logic [31:0]               r_adtre, n_adtre;
    logic [31:0]               r_sr29, n_sr29;
    logic                      r_sr31, n_sr31;
    logic                      r_halt, n_halt;

    function automatic logic cond_eval(input logic [3:0] flags, input logic [4:0] id);
        logic z, s, ov, cy, r;
        z  = flags[0];
        s  = flags[1];
        ov = flags[2];
        cy = flags[3];
        case (id[2:0])
            3'd0:    r = ov;
            3'd1:    r = cy;
            3'd2:    r = z;
            3'd3:    r = cy | z;
            3'd4:    r = s;
            3'd5:    r = 1'b1;
            3'd6:    r = s ^ ov;
            default: r = (s ^ ov) | z;
        endcase
        return id[4] ? 1'b0 : (r ^ id[3]);
    endfunction

    always_comb begin
        logic [esru_pkg::IRQ_W-1:0] irq_eff;
        logic                       irq_found;
        logic [esru_pkg::LVL_W-1:0] irq_lvl;
        logic                       exc_take;
        logic [15:0]                code;
        logic [3:0]                 new_lvl;
        logic [31:0]                psw_word;

        n_eipc     = r_eipc;
        n_eipsw    = r_eipsw;
        n_fepc     = r_fepc;
        n_fepsw    = r_fepsw;
        n_ecr      = r_ecr;
        n_psw      = r_psw;
        n_cache_en = r_cache_en;
        n_adtre    = r_adtre;
        n_sr29     = r_sr29;
        n_sr31     = r_sr31;
        n_halt     = r_halt;
        o_result   = '0;
        psw_word   = {12'b0, r_psw};

        // highest pending level wins
        irq_found = 1'b0;
        irq_lvl   = '0;
        for (int l = 0; l < esru_pkg::IRQ_W; l++) begin
            irq_eff[l] = i_item.irq_lines[l] && (l < NUM_CHK);
            if (irq_eff[l]) begin
                irq_found = 1'b1;
                irq_lvl   = esru_pkg::LVL_W'(l);
            end
        end

        exc_take = 1'b0;
        new_lvl  = '0;
        code     = i_item.exception_code;

        case (i_item.opcode)
            esru_pkg::OP_WRITE: begin
                case (i_item.target_id)
                    esru_pkg::SR_EIPC:  n_eipc = {i_item.write_value[31:1], 1'b0};
                    esru_pkg::SR_EIPSW: n_eipsw = i_item.write_value;
                    esru_pkg::SR_FEPC:  n_fepc = {i_item.write_value[31:1], 1'b0};
                    esru_pkg::SR_FEPSW: n_fepsw = i_item.write_value;
                    esru_pkg::SR_PSW:
                        n_psw = i_item.write_value[esru_pkg::PSW_W-1:0] & esru_pkg::PSW_MASK;
                    esru_pkg::SR_CHCW:  n_cache_en = i_item.write_value[1];
                    esru_pkg::SR_ADTRE: n_adtre = {i_item.write_value[31:1], 1'b0};
                    esru_pkg::SR_SR29:  n_sr29 = i_item.write_value;
                    esru_pkg::SR_SR31:  n_sr31 = i_item.write_value[0];
                    default: ;
                endcase
            end
            esru_pkg::OP_READ: begin
                case (i_item.target_id)
                    esru_pkg::SR_EIPC:  o_result.read_value = r_eipc;
                    esru_pkg::SR_EIPSW: o_result.read_value = r_eipsw;
                    esru_pkg::SR_FEPC:  o_result.read_value = r_fepc;
                    esru_pkg::SR_FEPSW: o_result.read_value = r_fepsw;
                    esru_pkg::SR_ECR:   o_result.read_value = r_ecr;
                    esru_pkg::SR_PSW:   o_result.read_value = psw_word;
                    esru_pkg::SR_PIR:   o_result.read_value = i_cfg.processor_id_value;
                    esru_pkg::SR_TKCW:  o_result.read_value = i_cfg.task_control_value;
                    esru_pkg::SR_CHCW:  o_result.read_value = {30'b0, r_cache_en, 1'b0};
                    esru_pkg::SR_ADTRE: o_result.read_value = r_adtre;
                    esru_pkg::SR_SR29:  o_result.read_value = r_sr29;
                    esru_pkg::SR_SR30:  o_result.read_value = i_cfg.sr30_value;
                    esru_pkg::SR_SR31:  o_result.read_value = {31'b0, r_sr31};
                    default:            o_result.read_value = '0;
                endcase
            end
            esru_pkg::OP_COND: begin
                o_result.condition_true = cond_eval(r_psw[3:0], i_item.target_id);
            end
            esru_pkg::OP_IRQ: begin
                exc_take = irq_found && !r_psw[esru_pkg::PSW_NP_B]
                        && !r_psw[esru_pkg::PSW_EP_B] && !r_psw[esru_pkg::PSW_ID_B]
                        && ({1'b0, r_psw[19:16]} <= {2'b0, irq_lvl});
                code = {esru_pkg::CODE_IRQ_HI, 1'b0, irq_lvl, 4'h0};
            end
            esru_pkg::OP_EXC: begin
                exc_take = 1'b1;
            end
            default: ;
        endcase

        if (exc_take) begin
            if (r_psw[esru_pkg::PSW_NP_B]) begin
                // fatal: only the halt flag changes
                o_result.fatal_valid = 1'b1;
                o_result.fatal_word  = {esru_pkg::FATAL_HI, code};
                n_halt               = 1'b1;
            end else begin
                if (r_psw[esru_pkg::PSW_EP_B]) begin
                    n_fepc                      = i_item.current_pc;
                    n_fepsw                     = psw_word;
                    n_ecr                       = {code, r_ecr[15:0]};
                    n_psw[esru_pkg::PSW_NP_B]   = 1'b1;
                    o_result.new_pc             = esru_pkg::VEC_DUPLEXED;
                end else begin
                    n_eipc                      = i_item.current_pc;
                    n_eipsw                     = psw_word;
                    n_ecr                       = {16'b0, code};
                    n_psw[esru_pkg::PSW_EP_B]   = 1'b1;
                    o_result.new_pc = {esru_pkg::VEC_HI,
                        (code == esru_pkg::CODE_SPECIAL) ? esru_pkg::VEC_SPECIAL
                                                         : (code & esru_pkg::VEC_LO_MASK)};
                end
                if (code[15:8] == esru_pkg::CODE_IRQ_HI) begin
                    new_lvl       = (code[7:4] == 4'hF) ? 4'hF : code[7:4] + 4'd1;
                    n_psw[19:16]  = new_lvl;
                    n_halt        = 1'b0;
                end
                n_psw[esru_pkg::PSW_ID_B] = 1'b1;
                n_psw[esru_pkg::PSW_AE_B] = 1'b0;
                o_result.pc_redirect      = 1'b1;
            end
        end

        o_result.halted = n_halt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eipc     <= '0;
            r_eipsw    <= '0;
            r_fepc     <= '0;
            r_fepsw    <= '0;
            r_ecr      <= '0;
            r_psw      <= '0;
            r_cache_en <= 1'b0;
            r_adtre    <= '0;
            r_sr29     <= '0;
            r_sr31     <= 1'b0;
            r_halt     <= 1'b0;
        end else if (i_en) begin
            r_eipc     <= n_eipc;
            r_eipsw    <= n_eipsw;
            r_fepc     <= n_fepc;
            r_fepsw    <= n_fepsw;
            r_ecr      <= n_ecr;
            r_psw      <= n_psw;
            r_cache_en <= n_cache_en;
            r_adtre    <= n_adtre;
            r_sr29     <= n_sr29;
            r_sr31     <= n_sr31;
            r_halt     <= n_halt;
        end
    end

endmodule

>>> design/exception_and_system_register_unit.sv
// System register and exception unit. Each item is one operation: register write or read,
// branch condition test, interrupt check or exception raise. An accepted item sits in the
// input register until the output register is empty or being drained, is executed there
// against the system registers and its result lands in the output register; one item per
// cycle is sustained while the result side keeps up. The configuration port is always
// ready; write it only while the unit is idle. Only the lowest IRQ_LEVELS request lines
// (at most five) are considered.
module exception_and_system_register_unit #(
    parameter int IRQ_LEVELS = esru_pkg::IRQ_LEVELS_DF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  esru_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output esru_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [esru_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    logic                r_in_valid;
    esru_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    esru_pkg::t_out_item r_out_item;
    esru_pkg::t_cfg      r_cfg;
    esru_pkg::t_out_item exec_result;
    logic                advance;

    // the executing item moves on when the output register is empty or being drained
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                esru_pkg::CFG_PIR:  r_cfg.processor_id_value <= i_cfg_data;
                esru_pkg::CFG_TKCW: r_cfg.task_control_value <= i_cfg_data;
                esru_pkg::CFG_SR30: r_cfg.sr30_value         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= exec_result;
        end
    end

    esru_core #(
        .IRQ_LEVELS (IRQ_LEVELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (exec_result)
    );

`ifndef SYNTH
    a_fatal_no_redirect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.fatal_valid |-> !r_out_item.pc_redirect)
        else $error("fatal item also redirects");

    a_vector_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.pc_redirect |-> (r_out_item.new_pc[31:16] == 16'hFFFF))
        else $error("redirect vector outside handler area");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("executed item lost");

    a_fatal_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.fatal_valid |-> r_out_item.halted)
        else $error("fatal item without halt");
`endif

endmodule

>>> bench/esru_checker.sv
module esru_checker
    import esru_pkg::*;
#(
    parameter int IRQ_LEVELS = IRQ_LEVELS_DF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // branch conditions; bit 3 of the condition number negates
    typedef enum logic [2:0] {
        CC_V, CC_C, CC_Z, CC_NH, CC_N, CC_T, CC_LT, CC_LE
    } t_cond_base;

    logic [31:0] cfg_pir, cfg_tkcw, cfg_sr30;
    logic [31:0] eipc, eipsw, fepc, fepsw, ecr, adtre, sr29;
    logic [PSW_W-1:0] psw;
    logic chcw_en, sr31, halt_q;

    t_out_item expected_results[$];
    int fail_total  = 0;
    int outstanding = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = outstanding;

    function automatic logic [31:0] sysreg_value(logic [4:0] id);
        case (id)
            SR_EIPC:  return eipc;
            SR_EIPSW: return eipsw;
            SR_FEPC:  return fepc;
            SR_FEPSW: return fepsw;
            SR_ECR:   return ecr;
            SR_PSW:   return {{(32-PSW_W){1'b0}}, psw & PSW_MASK};
            SR_PIR:   return cfg_pir;
            SR_TKCW:  return cfg_tkcw;
            SR_CHCW:  return {30'b0, chcw_en, 1'b0};
            SR_ADTRE: return adtre;
            SR_SR29:  return sr29;
            SR_SR30:  return cfg_sr30;
            SR_SR31:  return {31'b0, sr31};
            default:  return '0;
        endcase
    endfunction

    function automatic void store_sysreg(logic [4:0] id, logic [31:0] v);
        case (id)
            SR_EIPC:  eipc    = {v[31:1], 1'b0};
            SR_EIPSW: eipsw   = v;
            SR_FEPC:  fepc    = {v[31:1], 1'b0};
            SR_FEPSW: fepsw   = v;
            SR_PSW:   psw     = v[PSW_W-1:0] & PSW_MASK;
            SR_CHCW:  chcw_en = v[1];
            SR_ADTRE: adtre   = {v[31:1], 1'b0};
            SR_SR29:  sr29    = v;
            SR_SR31:  sr31    = v[0];
            default: ;
        endcase
    endfunction

    function automatic logic branch_taken(logic [4:0] id);
        logic z, s, ov, cy, r;
        z  = psw[0];
        s  = psw[1];
        ov = psw[2];
        cy = psw[3];
        if (id > 5'd15)
            return 1'b0;
        case (t_cond_base'(id[2:0]))
            CC_V:    r = ov;
            CC_C:    r = cy;
            CC_Z:    r = z;
            CC_NH:   r = cy | z;
            CC_N:    r = s;
            CC_T:    r = 1'b1;
            CC_LT:   r = s ^ ov;
            default: r = (s ^ ov) | z;
        endcase
        return r ^ id[3];
    endfunction

    function automatic void take_exception(input logic [15:0] code, input logic [31:0] pc,
                                           inout t_out_item res);
        logic [3:0] lvl;
        if (psw[PSW_NP_B]) begin
            // fatal: only the halt flag moves
            res.fatal_valid = 1'b1;
            res.fatal_word  = {FATAL_HI, code};
            halt_q          = 1'b1;
            return;
        end
        if (psw[PSW_EP_B]) begin
            fepc  = pc;
            fepsw = {{(32-PSW_W){1'b0}}, psw & PSW_MASK};
            ecr   = {code, ecr[15:0]};
            psw[PSW_NP_B] = 1'b1;
            res.new_pc    = VEC_DUPLEXED;
        end else begin
            eipc  = pc;
            eipsw = {{(32-PSW_W){1'b0}}, psw & PSW_MASK};
            ecr   = {16'b0, code};
            psw[PSW_EP_B] = 1'b1;
            res.new_pc = {VEC_HI, (code == CODE_SPECIAL) ? VEC_SPECIAL : (code & VEC_LO_MASK)};
        end
        res.pc_redirect = 1'b1;
        if (code[15:8] == CODE_IRQ_HI) begin
            lvl = (code[7:4] == 4'hF) ? 4'hF : code[7:4] + 4'd1;
            psw[PSW_W-1 -: 4] = lvl;
            halt_q = 1'b0;
        end
        psw[PSW_ID_B] = 1'b1;
        psw[PSW_AE_B] = 1'b0;
        psw = psw & PSW_MASK;
    endfunction

    function automatic t_out_item execute_op(t_in_item it);
        t_out_item res;
        int level;
        res   = '0;
        level = -1;
        case (it.opcode)
            OP_WRITE: store_sysreg(it.target_id, it.write_value);
            OP_READ:  res.read_value = sysreg_value(it.target_id);
            OP_COND:  res.condition_true = branch_taken(it.target_id);
            OP_IRQ: begin
                for (int l = IRQ_LEVELS - 1; l >= 0; l--)
                    if (level < 0 && l < IRQ_W && it.irq_lines[l])
                        level = l;
                if (level >= 0 && !psw[PSW_NP_B] && !psw[PSW_EP_B] && !psw[PSW_ID_B] &&
                    int'(psw[PSW_W-1 -: 4]) <= level)
                    take_exception({CODE_IRQ_HI, 4'(level), 4'h0}, it.current_pc, res);
            end
            OP_EXC: take_exception(it.exception_code, it.current_pc, res);
            default: ;
        endcase
        res.halted = halt_q;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_pir  = '0;
            cfg_tkcw = '0;
            cfg_sr30 = '0;
            eipc     = '0;
            eipsw    = '0;
            fepc     = '0;
            fepsw    = '0;
            ecr      = '0;
            psw      = '0;
            chcw_en  = 1'b0;
            adtre    = '0;
            sr29     = '0;
            sr31     = 1'b0;
            halt_q   = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PIR:  cfg_pir  = i_cfg_data;
                    CFG_TKCW: cfg_tkcw = i_cfg_data;
                    CFG_SR30: cfg_sr30 = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with no item outstanding, expected none, got %p",
                             $time, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_value", want.read_value, i_out_data.read_value);
                    check_field("condition_true", 32'(want.condition_true),
                                32'(i_out_data.condition_true));
                    check_field("pc_redirect", 32'(want.pc_redirect),
                                32'(i_out_data.pc_redirect));
                    check_field("new_pc", want.new_pc, i_out_data.new_pc);
                    check_field("fatal_valid", 32'(want.fatal_valid),
                                32'(i_out_data.fatal_valid));
                    check_field("fatal_word", want.fatal_word, i_out_data.fatal_word);
                    check_field("halted", 32'(want.halted), 32'(i_out_data.halted));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(execute_op(i_in_data));
        end
        outstanding = expected_results.size();
    end

endmodule

>>> bench/exception_and_system_register_unit_tb.sv
module exception_and_system_register_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esru_pkg::*;

    localparam int IRQ_LEVELS  = IRQ_LEVELS_DF;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    int                   fail_count;
    int                   pending;

    int gap_pct   = 10;
    int stall_pct = 10;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    exception_and_system_register_unit #(
        .IRQ_LEVELS(IRQ_LEVELS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    esru_checker #(
        .IRQ_LEVELS(IRQ_LEVELS)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 clk = ~clk;

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // result side: random stall, plus one long hold-off on request
    always begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
            out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [4:0] known_sysreg();
        case ($urandom_range(12))
            0:       return SR_EIPC;
            1:       return SR_EIPSW;
            2:       return SR_FEPC;
            3:       return SR_FEPSW;
            4:       return SR_ECR;
            5:       return SR_PSW;
            6:       return SR_PIR;
            7:       return SR_TKCW;
            8:       return SR_CHCW;
            9:       return SR_ADTRE;
            10:      return SR_SR29;
            11:      return SR_SR30;
            default: return SR_SR31;
        endcase
    endfunction

    function automatic t_in_item op_item(logic [2:0] op, logic [4:0] id, logic [31:0] wv,
                                         logic [15:0] code, logic [4:0] irq);
        t_in_item it;
        it.opcode         = op;
        it.target_id      = id;
        it.write_value    = wv;
        it.exception_code = code;
        it.current_pc     = $urandom();
        it.irq_lines      = irq;
        return it;
    endfunction

    function automatic t_in_item random_op();
        t_in_item it;
        int pick;
        it.opcode         = OP_WRITE;
        it.target_id      = 5'($urandom_range(31));
        it.write_value    = $urandom();
        it.exception_code = 16'($urandom());
        it.current_pc     = $urandom();
        it.irq_lines      = 5'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 30) begin
            if ($urandom_range(1) == 1)
                it.target_id = SR_PSW;
            else if ($urandom_range(1) == 1)
                it.target_id = known_sysreg();
            // mostly drop NP, EP and ID so interrupts and regular exceptions keep recurring
            if (it.target_id == SR_PSW && $urandom_range(3) != 0) begin
                it.write_value[PSW_NP_B] = 1'b0;
                it.write_value[PSW_EP_B] = 1'b0;
                it.write_value[PSW_ID_B] = 1'b0;
                it.write_value[PSW_W-1 -: 4] = 4'($urandom_range(5));
            end
        end else if (pick < 50) begin
            it.opcode = OP_READ;
            if ($urandom_range(3) != 0)
                it.target_id = known_sysreg();
        end else if (pick < 65) begin
            it.opcode = OP_COND;
            if ($urandom_range(3) != 0)
                it.target_id = 5'($urandom_range(15));
        end else if (pick < 80) begin
            it.opcode = OP_IRQ;
        end else if (pick < 95) begin
            it.opcode = OP_EXC;
            case ($urandom_range(3))
                0:       it.exception_code[15:8] = CODE_IRQ_HI;
                1:       it.exception_code = CODE_SPECIAL;
                default: ;
            endcase
        end else begin
            it.opcode = 3'($urandom_range(7, int'(OP_EXC) + 1));
        end
        return it;
    endfunction

    task automatic send_op(input t_in_item it);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_cfg(CFG_PIR, '1);
        write_cfg(CFG_TKCW, '0);
        write_cfg(CFG_SR30, '1);

        // masked writes, read-only targets, unused numbers
        send_op(op_item(OP_WRITE, SR_EIPC, '1, '0, '0));
        send_op(op_item(OP_READ,  SR_EIPC, '0, '0, '0));
        send_op(op_item(OP_WRITE, SR_SR31, '1, '0, '0));
        send_op(op_item(OP_READ,  SR_SR31, '0, '0, '0));
        send_op(op_item(OP_WRITE, SR_CHCW, '1, '0, '0));
        send_op(op_item(OP_READ,  SR_CHCW, '0, '0, '0));
        send_op(op_item(OP_WRITE, SR_ECR,  '1, '1, '1));
        send_op(op_item(OP_WRITE, SR_PIR,  '0, '0, '0));
        send_op(op_item(OP_READ,  SR_ECR,  '0, '0, '0));
        send_op(op_item(OP_READ,  SR_PIR,  '0, '0, '0));
        send_op(op_item(OP_READ,  SR_TKCW, '1, '1, '1));
        send_op(op_item(OP_READ,  SR_SR30, '0, '0, '0));
        send_op(op_item(OP_READ,  5'($urandom_range(23, 8)), '0, '0, '0));
        // flags up, then conditions in and out of range
        send_op(op_item(OP_WRITE, SR_PSW, 32'h0000_000F, '0, '0));
        send_op(op_item(OP_COND,  5'($urandom_range(15)), '0, '0, '0));
        send_op(op_item(OP_COND,  5'($urandom_range(31, 16)), '0, '0, '0));
        // interrupts: none pending, taken, then masked by EP/ID
        send_op(op_item(OP_IRQ, '0, '0, '0, '0));
        send_op(op_item(OP_IRQ, '0, '0, '0, '1));
        send_op(op_item(OP_IRQ, '0, '0, '0, '1));
        // duplexed then fatal
        send_op(op_item(OP_EXC, '0, '0, CODE_SPECIAL, '0));
        send_op(op_item(OP_EXC, '0, '0, '1, '0));
        send_op(op_item(OP_READ, SR_FEPSW, '0, '0, '0));
        // level mask alone blocks the interrupt
        send_op(op_item(OP_WRITE, SR_PSW, 32'h000F_0000, '0, '0));
        send_op(op_item(OP_IRQ, '0, '0, '0, '1));
        send_op(op_item(OP_WRITE, SR_PSW, '0, '0, '0));
        send_op(op_item(OP_EXC, '0, '0, CODE_SPECIAL, '0));
        // interrupt-class code with saturating level, taken in duplexed form
        send_op(op_item(OP_EXC, '0, '0, {CODE_IRQ_HI, 8'hF0}, '0));
        send_op(op_item(OP_READ, SR_PSW, '0, '0, '0));
        send_op(op_item(3'($urandom_range(7, int'(OP_EXC) + 1)), '1, '1, '1, '1));
        drain();

        write_cfg(CFG_PIR, '0);
        write_cfg(CFG_TKCW, '1);
        write_cfg(CFG_SR30, '0);
        repeat (450) send_op(random_op());
        drain();

        write_cfg(CFG_PIR, $urandom());
        write_cfg(CFG_TKCW, $urandom());
        write_cfg(CFG_SR30, $urandom());
        gap_pct   = 0;
        stall_pct = 0;
        repeat (300) send_op(random_op());
        drain();

        write_cfg(CFG_PIR, $urandom());
        write_cfg(CFG_TKCW, $urandom());
        write_cfg(CFG_SR30, $urandom());
        gap_pct   = 10;
        stall_pct = 10;
        for (int n = 0; n < 600; n++) begin
            if (n == 100)
                hold_req = 1'b1;
            send_op(random_op());
        end
        drain();

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
